/* hw/rtl/bpd_pkg.sv */
// ============================================================================
// bpd_pkg
// Shared types and constants of the BMP pixel array decoder.
// ============================================================================
package bpd_pkg;

    localparam int MAX_WIDTH     = 4096;
    localparam int MAX_HEIGHT    = 4096;
    localparam int PALETTE_DEPTH = 256;
    localparam int BYTE_W        = 8;
    localparam int RGB_W         = 3 * BYTE_W;
    localparam int PIXELS_MAX    = 8;

    localparam int WIDTH_W    = $clog2(MAX_WIDTH + 1);
    localparam int HEIGHT_W   = $clog2(MAX_HEIGHT + 1);
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int CNT_W      = $clog2(PIXELS_MAX + 1);
    localparam int K_W        = $clog2(PIXELS_MAX);
    localparam int PAL_W      = $clog2(PALETTE_DEPTH);
    localparam int BITS_W     = WIDTH_W + 5;
    localparam int STRIDE_W   = BITS_W - 3;
    localparam int CFG_DATA_W = 13;
    localparam int CFG_IDX_W  = 2;

    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 48;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic OP_PALETTE = 1'b0;
    localparam logic OP_PIXEL   = 1'b1;

    typedef enum logic [1:0] {
        MODE_1BPP,
        MODE_4BPP,
        MODE_8BPP,
        MODE_24BPP
    } bpd_mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WIDTH,
        CFG_HEIGHT,
        CFG_MODE
    } bpd_cfg_idx_t;

    typedef enum logic [1:0] {
        PHASE_BLUE,
        PHASE_GREEN,
        PHASE_RED
    } bpd_phase_t;

    typedef struct packed {
        logic                is_write;
        logic [PAL_W-1:0]    addr;
        logic [RGB_W-1:0]    rgb;
        bpd_mode_t           mode;
        logic [CNT_W-1:0]    cnt;
        logic [COL_W-1:0]    col;
        logic [ROW_W-1:0]    row;
        logic                done;
    } bpd_entry_t;

endpackage

/* hw/rtl/bpd_front.sv */
// ============================================================================
// bpd_front
// Accepts input beats, tracks the row position and packs pixel and palette work entries.
// ============================================================================
module bpd_front (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [bpd_pkg::S_DATA_W-1:0]      s_tdata,
    input  logic                              s_tuser,
    input  logic                              cfg_we,
    input  logic [bpd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [bpd_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                              q_full,
    output logic                              q_push,
    output bpd_pkg::bpd_entry_t               q_entry
);
    import bpd_pkg::*;

    logic [WIDTH_W-1:0]  width_reg, width_next;
    logic [HEIGHT_W-1:0] height_reg, height_next;
    bpd_mode_t           mode_reg, mode_next;

    logic [STRIDE_W-1:0] byte_in_row_reg, byte_in_row_next;
    logic [ROW_W-1:0]    file_row_reg, file_row_next;
    logic [WIDTH_W-1:0]  next_col_reg, next_col_next;
    bpd_phase_t          phase_reg, phase_next;
    logic [BYTE_W-1:0]   held_blue_reg, held_blue_next;
    logic [BYTE_W-1:0]   held_green_reg, held_green_next;

    logic                accept;
    logic [BYTE_W-1:0]   data_byte;
    logic [BITS_W-1:0]   row_bits;
    logic [BITS_W-1:0]   row_bits_up;
    logic [STRIDE_W-1:0] stride;
    logic [STRIDE_W-1:0] byte_inc;
    logic [HEIGHT_W-1:0] row_inc;
    logic [WIDTH_W-1:0]  left;
    logic [CNT_W-1:0]    per;
    logic [CNT_W-1:0]    cnt;
    logic                last_row;

    assign s_tready  = !q_full;
    assign accept    = s_tvalid && s_tready;
    assign data_byte = s_tdata[39:32];

    always_comb
    begin
        case (mode_reg)
            MODE_1BPP:  row_bits = BITS_W'(width_reg);
            MODE_4BPP:  row_bits = BITS_W'(width_reg) << 2;
            MODE_8BPP:  row_bits = BITS_W'(width_reg) << 3;
            default:    row_bits = (BITS_W'(width_reg) << 4) + (BITS_W'(width_reg) << 3);
        endcase
    end

    assign row_bits_up = row_bits + BITS_W'(31);
    assign stride      = {row_bits_up[BITS_W-1:5], 2'b00};
    assign byte_inc    = byte_in_row_reg + STRIDE_W'(1);
    assign row_inc     = HEIGHT_W'(file_row_reg) + HEIGHT_W'(1);
    assign left        = width_reg - next_col_reg;
    assign last_row    = (HEIGHT_W'(file_row_reg) == height_reg - HEIGHT_W'(1));

    always_comb
    begin
        case (mode_reg)
            MODE_1BPP:  per = CNT_W'(8);
            MODE_4BPP:  per = CNT_W'(2);
            default:    per = CNT_W'(1);
        endcase
    end

    assign cnt = (left < WIDTH_W'(per)) ? CNT_W'(left) : per;

    always_comb
    begin
        width_next       = width_reg;
        height_next      = height_reg;
        mode_next        = mode_reg;
        byte_in_row_next = byte_in_row_reg;
        file_row_next    = file_row_reg;
        next_col_next    = next_col_reg;
        phase_next       = phase_reg;
        held_blue_next   = held_blue_reg;
        held_green_next  = held_green_reg;
        q_push           = 1'b0;

        q_entry          = '0;
        q_entry.addr     = data_byte;
        q_entry.mode     = mode_reg;
        q_entry.cnt      = cnt;
        q_entry.col      = COL_W'(next_col_reg);
        q_entry.row      = ROW_W'(height_reg - HEIGHT_W'(1) - HEIGHT_W'(file_row_reg));
        q_entry.done     = last_row && (next_col_reg + WIDTH_W'(cnt) == width_reg);

        if (cfg_we)
        begin
            case (cfg_index)
                CFG_WIDTH:
                begin
                    if (cfg_data == '0)
                        width_next = WIDTH_W'(1);
                    else if (int'(cfg_data) > MAX_WIDTH)
                        width_next = WIDTH_W'(MAX_WIDTH);
                    else
                        width_next = WIDTH_W'(cfg_data);
                end
                CFG_HEIGHT:
                begin
                    if (cfg_data == '0)
                        height_next = HEIGHT_W'(1);
                    else if (int'(cfg_data) > MAX_HEIGHT)
                        height_next = HEIGHT_W'(MAX_HEIGHT);
                    else
                        height_next = HEIGHT_W'(cfg_data);
                end
                CFG_MODE:
                begin
                    mode_next = bpd_mode_t'(cfg_data[1:0]);
                end
                default:
                begin
                end
            endcase
            if (cfg_index == CFG_WIDTH || cfg_index == CFG_HEIGHT || cfg_index == CFG_MODE)
            begin
                byte_in_row_next = '0;
                file_row_next    = '0;
                next_col_next    = '0;
                phase_next       = PHASE_BLUE;
            end
        end
        else if (accept)
        begin
            if (s_tuser == OP_PALETTE)
            begin
                q_push           = 1'b1;
                q_entry.is_write = 1'b1;
                q_entry.addr     = s_tdata[7:0];
                q_entry.rgb      = {s_tdata[15:8], s_tdata[23:16], s_tdata[31:24]};
            end
            else
            begin
                if (next_col_reg < width_reg)
                begin
                    if (mode_reg == MODE_24BPP)
                    begin
                        case (phase_reg)
                            PHASE_BLUE:
                            begin
                                held_blue_next = data_byte;
                                phase_next     = PHASE_GREEN;
                            end
                            PHASE_GREEN:
                            begin
                                held_green_next = data_byte;
                                phase_next      = PHASE_RED;
                            end
                            default:
                            begin
                                q_push        = 1'b1;
                                q_entry.rgb   = {data_byte, held_green_reg, held_blue_reg};
                                next_col_next = next_col_reg + WIDTH_W'(1);
                                phase_next    = PHASE_BLUE;
                            end
                        endcase
                    end
                    else
                    begin
                        q_push        = 1'b1;
                        next_col_next = next_col_reg + WIDTH_W'(cnt);
                    end
                end

                if (byte_inc >= stride)
                begin
                    byte_in_row_next = '0;
                    next_col_next    = '0;
                    phase_next       = PHASE_BLUE;
                    file_row_next    = (row_inc >= height_reg) ? '0 : ROW_W'(row_inc);
                end
                else
                begin
                    byte_in_row_next = byte_inc;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg       <= WIDTH_W'(1);
            height_reg      <= HEIGHT_W'(1);
            mode_reg        <= MODE_24BPP;
            byte_in_row_reg <= '0;
            file_row_reg    <= '0;
            next_col_reg    <= '0;
            phase_reg       <= PHASE_BLUE;
            held_blue_reg   <= '0;
            held_green_reg  <= '0;
        end
        else
        begin
            width_reg       <= width_next;
            height_reg      <= height_next;
            mode_reg        <= mode_next;
            byte_in_row_reg <= byte_in_row_next;
            file_row_reg    <= file_row_next;
            next_col_reg    <= next_col_next;
            phase_reg       <= phase_next;
            held_blue_reg   <= held_blue_next;
            held_green_reg  <= held_green_next;
        end
    end

endmodule

/* hw/rtl/bpd_fifo.sv */
// ============================================================================
// bpd_fifo
// Short queue of work entries between the front and the back.
// ============================================================================
module bpd_fifo (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  bpd_pkg::bpd_entry_t    push_entry,
    input  logic                   pop,
    output bpd_pkg::bpd_entry_t    head,
    output logic                   empty,
    output logic                   full
);
    import bpd_pkg::*;

    bpd_entry_t        slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]   count_reg, count_next;
    logic              do_push;
    logic              do_pop;

    assign empty   = (count_reg == '0);
    assign full    = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign head    = slot_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + (QPTR_W+1)'(1);
        else if (!do_push && do_pop)
            count_next = count_reg - (QPTR_W+1)'(1);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

/* hw/rtl/bpd_back.sv */
// ============================================================================
// bpd_back
// Expands work entries into pixels, owns the palette RAM and the output beat.
// ============================================================================
module bpd_back (
    input  logic                            clk,
    input  logic                            rst_n,
    input  bpd_pkg::bpd_entry_t             head,
    input  logic                            empty,
    output logic                            pop,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [bpd_pkg::M_DATA_W-1:0]    m_tdata,
    output logic                            m_tlast,
    output logic                            m_tuser
);
    import bpd_pkg::*;

    logic [RGB_W-1:0] palette_mem [PALETTE_DEPTH];

    logic [K_W-1:0]   k_reg, k_next;
    logic             out_v_reg, out_v_next;
    logic [RGB_W-1:0] rd_reg;
    logic             direct_reg;
    logic [RGB_W-1:0] direct_rgb_reg;
    logic [COL_W-1:0] col_reg;
    logic [ROW_W-1:0] row_reg;
    logic             last_reg;
    logic             done_reg;

    logic             issue_valid;
    logic             advance;
    logic             fire;
    logic             last_k;
    logic             pal_write;
    logic [PAL_W-1:0] pal_idx;
    logic [RGB_W-1:0] out_rgb;

    assign pal_write   = !empty && head.is_write;
    assign issue_valid = !empty && !head.is_write;
    assign advance     = !out_v_reg || m_tready;
    assign fire        = issue_valid && advance;
    assign last_k      = (CNT_W'(k_reg) + CNT_W'(1) == head.cnt);
    assign pop         = pal_write || (fire && last_k);

    always_comb
    begin
        case (head.mode)
            MODE_1BPP:  pal_idx = PAL_W'(head.addr[K_W'(PIXELS_MAX - 1) - k_reg]);
            MODE_4BPP:  pal_idx = k_reg[0] ? PAL_W'(head.addr[3:0]) : PAL_W'(head.addr[7:4]);
            default:    pal_idx = head.addr;
        endcase
    end

    always_comb
    begin
        k_next     = k_reg;
        out_v_next = out_v_reg;
        if (fire)
            k_next = last_k ? '0 : k_reg + K_W'(1);
        if (advance)
            out_v_next = fire;
    end

    always_ff @(posedge clk)
    begin
        if (pal_write)
            palette_mem[head.addr] <= head.rgb;
        if (fire)
            rd_reg <= palette_mem[pal_idx];
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            direct_reg     <= (head.mode == MODE_24BPP);
            direct_rgb_reg <= head.rgb;
            col_reg        <= head.col + COL_W'(k_reg);
            row_reg        <= head.row;
            last_reg       <= last_k;
            done_reg       <= head.done && last_k;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg     <= '0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            k_reg     <= k_next;
            out_v_reg <= out_v_next;
        end
    end

    assign out_rgb  = direct_reg ? direct_rgb_reg : rd_reg;
    assign m_tvalid = out_v_reg;
    assign m_tdata  = {row_reg, col_reg, out_rgb[7:0], out_rgb[15:8], out_rgb[23:16]};
    assign m_tlast  = last_reg;
    assign m_tuser  = done_reg;

endmodule

/* hw/rtl/bmp_pixel_array_decoder.sv */
// A data beat is registered in the work queue, then each pixel in the output register.
// One pixel beat per cycle unless m_tready or an empty queue stalls; a byte gives 8
// pixels at 1 bpp, 2 at 4 bpp, 1 at 8 bpp; at 24 bpp one byte per cycle is accepted
// unless the queue is full. The single palette RAM read port sets the pixel rate.
// Reset: position cleared, width 1, height 1, 24 bpp; palette holds no value.
// ============================================================================
// bmp_pixel_array_decoder
// BMP pixel array decoder for 1, 4, 8 and 24 bits per pixel.
// ============================================================================
module bmp_pixel_array_decoder (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // palette_index, palette_red, palette_green, palette_blue, data_byte
    input  logic [bpd_pkg::S_DATA_W-1:0]      s_tdata,
    // op
    input  logic                              s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // red, green, blue, pixel_column, pixel_row
    output logic [bpd_pkg::M_DATA_W-1:0]      m_tdata,
    output logic                              m_tlast,
    // image_done
    output logic                              m_tuser,
    input  logic                              cfg_we,
    input  logic [bpd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [bpd_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import bpd_pkg::*;

    bpd_entry_t q_entry;
    bpd_entry_t q_head;
    logic       q_push;
    logic       q_pop;
    logic       q_empty;
    logic       q_full;

    bpd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_entry   (q_entry)
    );

    bpd_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_entry),
        .pop        (q_pop),
        .head       (q_head),
        .empty      (q_empty),
        .full       (q_full)
    );

    bpd_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (q_head),
        .empty    (q_empty),
        .pop      (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

/* hw/rtl/bpd_checker.sv */
// ============================================================================
// bpd_checker
// Port-level checks on the pixel output stream of the decoder.
// ============================================================================
module bpd_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [bpd_pkg::M_DATA_W-1:0]    m_tdata,
    input  logic                            m_tlast,
    input  logic                            m_tuser
);
    import bpd_pkg::*;

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("output beat dropped while stalled");

    a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tlast)
        else $error("image end not on last pixel of its byte");

    a_done_top_row: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata[47:36] == '0)
        else $error("image end outside top row");

    a_idle_after_reset: assert property (@(posedge clk)
        $rose(rst_n) |-> !m_tvalid)
        else $error("output beat right after reset");

endmodule

bind bmp_pixel_array_decoder bpd_checker u_bpd_checker (.*);
